>>> design/eba_pkg.sv
// ----------------------------------------------------------------------------
// Extent block allocator package
// Shared constants, configuration register indexes and channel payloads.
// ----------------------------------------------------------------------------
package eba_pkg;

    localparam int EXTENT_SLOTS  = 8;
    localparam int SLOT_IDX_W    = (EXTENT_SLOTS > 1) ? $clog2(EXTENT_SLOTS) : 1;
    localparam int SLOT_CNT_W    = $clog2(EXTENT_SLOTS + 1);
    // Sum of all extent lengths, with headroom for the slot count.
    localparam int TOTAL_W       = 33 + $clog2(EXTENT_SLOTS);
    // The shared adder carries one extra bit so that its top bit is a sign.
    localparam int ALU_W         = TOTAL_W + 1;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;
    localparam int BLOCK_BYTES_W = 17;
    localparam int PROD_W        = 32 + BLOCK_BYTES_W;

    // An inode takes one block for itself plus one per extent slot.
    localparam logic [31:0] INODE_SPAN        = 32'(EXTENT_SLOTS + 1);
    localparam logic [31:0] FIRST_EXTENT_LEN  = 32'(EXTENT_SLOTS);
    localparam logic [BLOCK_BYTES_W-1:0] BLOCK_BYTES_RESET = 17'd4096;

    localparam logic FUNC_NEW_INODE  = 1'b0;
    localparam logic FUNC_RESERVE    = 1'b1;
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_NO_SPACE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RING_BASE   = 2'd0,
        CFG_DISK_BLOCKS = 2'd1,
        CFG_BLOCK_BYTES = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic        func;
        logic [31:0] cover_block;
    } req_t;

    typedef struct packed {
        logic        status;
        logic [31:0] inode_number;
        logic [31:0] first_block;
        logic [5:0]  extent_slot;
        logic [31:0] block_total;
        logic [31:0] byte_total;
        logic [31:0] next_free;
    } rsp_t;

endpackage

>>> design/eba_req_if.sv
// ----------------------------------------------------------------------------
// Extent block allocator request channel
// Valid/ready channel carrying one allocation request per transaction.
// ----------------------------------------------------------------------------
interface eba_req_if;
    import eba_pkg::*;

    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/eba_rsp_if.sv
// ----------------------------------------------------------------------------
// Extent block allocator response channel
// Valid/ready channel carrying one allocation result per transaction.
// ----------------------------------------------------------------------------
interface eba_rsp_if;
    import eba_pkg::*;

    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/extent_block_allocator_top.sv
// ----------------------------------------------------------------------------
// Extent block allocator
// Bump-pointer block allocator over a ring, with an inode counter and the
// extent table of one file, sequenced around a single shared adder.
// ----------------------------------------------------------------------------
// Each request is worked through a small sequencer that steps one shared
// 37-bit adder/subtractor through the pointer, limit, merge and total
// calculations, followed by one 32x17 multiply for the byte size. The
// shortest path is a reserve that is already covered; the longest is a
// reserve on a limited disk that wraps to the ring base and then cannot
// merge, so takes a new slot. The request channel is ready only while the
// sequencer is idle, so it returns to idle between requests. The result
// sits in an output register, so a new transaction may be taken while the
// previous result is still waiting to be collected; the sequencer then holds
// in its last step until it is.
// Configuration registers are written through a plain write port and should
// only be changed while no request is in flight.
// ----------------------------------------------------------------------------
module extent_block_allocator_top (
    input  logic                          clk,
    input  logic                          rst_n,
    eba_req_if.sink                       req,
    eba_rsp_if.source                     rsp,
    input  logic                          cfg_we,
    input  logic [eba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [eba_pkg::CFG_DATA_W-1:0] cfg_data
);
    import eba_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NEED,
        ST_PMAX,
        ST_SUM,
        ST_CMP,
        ST_START,
        ST_INODE,
        ST_END,
        ST_MCHK,
        ST_NEW,
        ST_TOTAL,
        ST_MUL,
        ST_OUT
    } state_t;

    state_t                   state_reg;

    logic [31:0]              ring_base_reg;
    logic [31:0]              disk_blocks_reg;
    logic [BLOCK_BYTES_W-1:0] block_bytes_reg;

    logic [31:0]              last_used_reg;
    logic [31:0]              inode_counter_reg;
    logic [31:0]              extent_start_reg  [EXTENT_SLOTS];
    logic [31:0]              extent_length_reg [EXTENT_SLOTS];
    logic [SLOT_CNT_W-1:0]    slot_cnt_reg;
    logic [TOTAL_W-1:0]       total_reg;

    logic                     func_reg;
    logic [32:0]              need1_reg;
    logic [31:0]              cnt_reg;
    logic [31:0]              p_reg;
    logic [32:0]              sum_reg;
    logic [31:0]              start_reg;
    logic [31:0]              end_reg;
    logic                     retry_reg;
    logic                     status_reg;
    logic [31:0]              first_reg;
    logic [SLOT_IDX_W-1:0]    slot_out_reg;
    logic [PROD_W-1:0]        prod_reg;

    logic                     out_valid_reg;
    rsp_t                     out_reg;

    logic [ALU_W-1:0]         alu_a;
    logic [ALU_W-1:0]         alu_b;
    logic                     alu_sub;
    logic [ALU_W-1:0]         alu_res;
    logic                     alu_neg;

    logic [SLOT_CNT_W-1:0]    tail_idx_full;
    logic [SLOT_IDX_W-1:0]    tail_idx;
    logic [SLOT_IDX_W-1:0]    new_idx;
    logic [31:0]              total_sat;
    logic [31:0]              byte_sat;
    logic                     req_accept;
    logic                     out_free;

    assign tail_idx_full = slot_cnt_reg - SLOT_CNT_W'(1);
    assign tail_idx      = tail_idx_full[SLOT_IDX_W-1:0];
    assign new_idx       = slot_cnt_reg[SLOT_IDX_W-1:0];

    assign total_sat = (|total_reg[TOTAL_W-1:32]) ? '1 : total_reg[31:0];
    assign byte_sat  = (|prod_reg[PROD_W-1:32]) ? '1 : prod_reg[31:0];

    assign req.ready  = (state_reg == ST_IDLE);
    assign req_accept = req.valid && req.ready;
    assign out_free   = !out_valid_reg || rsp.ready;

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    // Operand selection for the shared adder/subtractor.
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            ST_NEED:
            begin
                alu_a   = ALU_W'(need1_reg);
                alu_b   = ALU_W'(total_reg);
                alu_sub = 1'b1;
            end
            ST_PMAX:
            begin
                alu_a   = ALU_W'(last_used_reg);
                alu_b   = ALU_W'(ring_base_reg);
                alu_sub = 1'b1;
            end
            ST_SUM:
            begin
                alu_a = ALU_W'(p_reg);
                alu_b = ALU_W'(cnt_reg);
            end
            ST_CMP:
            begin
                alu_a   = ALU_W'(sum_reg);
                alu_b   = ALU_W'(disk_blocks_reg);
                alu_sub = 1'b1;
            end
            ST_START:
            begin
                alu_a = ALU_W'(p_reg);
                alu_b = ALU_W'(1);
            end
            ST_INODE:
            begin
                alu_a = ALU_W'(start_reg);
                alu_b = ALU_W'(1);
            end
            ST_END:
            begin
                alu_a = ALU_W'(extent_start_reg[tail_idx]);
                alu_b = ALU_W'(extent_length_reg[tail_idx]);
            end
            ST_MCHK:
            begin
                alu_a = ALU_W'(extent_length_reg[tail_idx]);
                alu_b = ALU_W'(cnt_reg);
            end
            ST_TOTAL:
            begin
                alu_a = ALU_W'(total_reg);
                alu_b = ALU_W'(cnt_reg);
            end
            default:
            begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    assign alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);
    assign alu_neg = alu_res[ALU_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            ring_base_reg     <= '0;
            disk_blocks_reg   <= '0;
            block_bytes_reg   <= BLOCK_BYTES_RESET;
            last_used_reg     <= '0;
            inode_counter_reg <= '0;
            for (int i = 0; i < EXTENT_SLOTS; i++)
            begin
                extent_start_reg[i]  <= '0;
                extent_length_reg[i] <= '0;
            end
            slot_cnt_reg      <= '0;
            total_reg         <= '0;
            func_reg          <= FUNC_NEW_INODE;
            need1_reg         <= '0;
            cnt_reg           <= '0;
            p_reg             <= '0;
            sum_reg           <= '0;
            start_reg         <= '0;
            end_reg           <= '0;
            retry_reg         <= 1'b0;
            status_reg        <= STATUS_OK;
            first_reg         <= '0;
            slot_out_reg      <= '0;
            prod_reg          <= '0;
            out_valid_reg     <= 1'b0;
            out_reg           <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RING_BASE:   ring_base_reg   <= cfg_data;
                    CFG_DISK_BLOCKS: disk_blocks_reg <= cfg_data;
                    CFG_BLOCK_BYTES: block_bytes_reg <= cfg_data[BLOCK_BYTES_W-1:0];
                    default:         ;
                endcase
            end

            // In the output step a free register is reloaded below instead.
            if (out_valid_reg && rsp.ready && (state_reg != ST_OUT))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (req_accept)
                    begin
                        func_reg     <= req.data.func;
                        need1_reg    <= {1'b0, req.data.cover_block} + 33'd1;
                        status_reg   <= STATUS_OK;
                        first_reg    <= '0;
                        slot_out_reg <= '0;
                        if (req.data.func == FUNC_NEW_INODE)
                        begin
                            inode_counter_reg <= inode_counter_reg + 32'd1;
                            cnt_reg           <= INODE_SPAN;
                            state_reg         <= ST_PMAX;
                        end
                        else
                        begin
                            state_reg <= ST_NEED;
                        end
                    end
                end
                ST_NEED:
                begin
                    // Blocks still needed is (cover_block + 1) - total.
                    if (alu_neg || (alu_res == '0))
                    begin
                        state_reg <= ST_MUL;
                    end
                    else if (alu_res[32])
                    begin
                        status_reg <= STATUS_NO_SPACE;
                        state_reg  <= ST_MUL;
                    end
                    else
                    begin
                        cnt_reg   <= alu_res[31:0];
                        state_reg <= ST_PMAX;
                    end
                end
                ST_PMAX:
                begin
                    p_reg     <= alu_neg ? ring_base_reg : last_used_reg;
                    retry_reg <= 1'b0;
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    sum_reg   <= alu_res[32:0];
                    state_reg <= (disk_blocks_reg == '0) ? ST_START : ST_CMP;
                end
                ST_CMP:
                begin
                    // The range must end strictly below the disk size; on a miss
                    // the pointer restarts once from the ring base.
                    if (!alu_neg)
                    begin
                        if (retry_reg)
                        begin
                            status_reg <= STATUS_NO_SPACE;
                            state_reg  <= ST_MUL;
                        end
                        else
                        begin
                            p_reg     <= ring_base_reg;
                            retry_reg <= 1'b1;
                            state_reg <= ST_SUM;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_START;
                    end
                end
                ST_START:
                begin
                    start_reg <= alu_res[31:0];
                    if (func_reg == FUNC_NEW_INODE)
                    begin
                        state_reg <= ST_INODE;
                    end
                    else if (slot_cnt_reg == '0)
                    begin
                        state_reg <= ST_NEW;
                    end
                    else
                    begin
                        state_reg <= ST_END;
                    end
                end
                ST_INODE:
                begin
                    for (int i = 1; i < EXTENT_SLOTS; i++)
                    begin
                        extent_start_reg[i]  <= '0;
                        extent_length_reg[i] <= '0;
                    end
                    extent_start_reg[0]  <= alu_res[31:0];
                    extent_length_reg[0] <= FIRST_EXTENT_LEN;
                    slot_cnt_reg         <= SLOT_CNT_W'(1);
                    total_reg            <= TOTAL_W'(EXTENT_SLOTS);
                    last_used_reg        <= sum_reg[31:0];
                    first_reg            <= start_reg;
                    state_reg            <= ST_MUL;
                end
                ST_END:
                begin
                    end_reg   <= alu_res[31:0];
                    state_reg <= ST_MCHK;
                end
                ST_MCHK:
                begin
                    // Merge only when contiguous and the length stays in 32 bits.
                    if ((end_reg == start_reg) && !alu_res[32])
                    begin
                        extent_length_reg[tail_idx] <= alu_res[31:0];
                        slot_out_reg                <= tail_idx;
                        first_reg                   <= start_reg;
                        last_used_reg               <= sum_reg[31:0];
                        state_reg                   <= ST_TOTAL;
                    end
                    else
                    begin
                        state_reg <= ST_NEW;
                    end
                end
                ST_NEW:
                begin
                    // With the table full the pointer is simply left untouched.
                    if (slot_cnt_reg == SLOT_CNT_W'(EXTENT_SLOTS))
                    begin
                        status_reg <= STATUS_NO_SPACE;
                        state_reg  <= ST_MUL;
                    end
                    else
                    begin
                        extent_start_reg[new_idx]  <= start_reg;
                        extent_length_reg[new_idx] <= cnt_reg;
                        slot_cnt_reg               <= slot_cnt_reg + SLOT_CNT_W'(1);
                        slot_out_reg               <= new_idx;
                        first_reg                  <= start_reg;
                        last_used_reg              <= sum_reg[31:0];
                        state_reg                  <= ST_TOTAL;
                    end
                end
                ST_TOTAL:
                begin
                    total_reg <= alu_res[TOTAL_W-1:0];
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    prod_reg  <= PROD_W'(total_sat) * PROD_W'(block_bytes_reg);
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg        <= 1'b1;
                        out_reg.status       <= status_reg;
                        out_reg.inode_number <= inode_counter_reg;
                        out_reg.first_block  <= first_reg;
                        out_reg.extent_slot  <= 6'(slot_out_reg);
                        out_reg.block_total  <= total_sat;
                        out_reg.byte_total   <= byte_sat;
                        out_reg.next_free    <= last_used_reg;
                        state_reg            <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
